@@ rtl/best_detection_select_decode_macros.svh @@
// Assertion macros for the detection select/decode block.
// Every use expects i_clk and i_rst_n in scope.
`ifndef BEST_DETECTION_SELECT_DECODE_MACROS_SVH
`define BEST_DETECTION_SELECT_DECODE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BDSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BDSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BDSD_ASSERT_IMP(lbl, ante, cons, msg)
`define BDSD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/bdsd_pkg.sv @@
package bdsd_pkg;

    // keypoint fields per column, and how many of them are live
    localparam int POINT_FIELDS = 5;
    localparam int POINT_COUNT  = 5;
    localparam int LIVE_POINTS  = (POINT_COUNT < POINT_FIELDS) ? POINT_COUNT : POINT_FIELDS;

    // config port
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 8'd1;
    localparam logic [15:0] SCALE_RESET     = 16'd4096;
    localparam logic [15:0] THRESHOLD_RESET = 16'd45875;

    // queue between selector and decoder
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // fractional bits dropped by the decoder
    localparam int SHIFT_BOX   = 17;   // corner: (2c - w) * s / 2^17
    localparam int SHIFT_SIZE  = 16;   // size:   w * s / 2^16
    localparam int SHIFT_POINT = 12;   // point:  p * s / 2^12

    typedef struct packed {
        logic [15:0]        score;
        logic signed [15:0] centre_x;
        logic signed [15:0] centre_y;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
        logic [31:0]        point_zero;
        logic [31:0]        point_one;
        logic [31:0]        point_two;
        logic [31:0]        point_three;
        logic [31:0]        point_four;
        logic               last_column;
    } t_col;

    typedef struct packed {
        logic [15:0]        best_score;
        logic signed [15:0] left_edge;
        logic signed [15:0] top_edge;
        logic signed [15:0] out_width;
        logic signed [15:0] out_height;
        logic [31:0]        image_point_zero;
        logic [31:0]        image_point_one;
        logic [31:0]        image_point_two;
        logic [31:0]        image_point_three;
        logic [31:0]        image_point_four;
    } t_det;

    // raw winning column, as held and as queued
    typedef struct packed {
        logic [15:0]                         score;
        logic signed [15:0]                  centre_x;
        logic signed [15:0]                  centre_y;
        logic [14:0]                         box_width;
        logic [14:0]                         box_height;
        logic [POINT_FIELDS-1:0][31:0]       points;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

@@ rtl/bdsd_ifs.sv @@
interface bdsd_col_if;
    logic          valid;
    logic          ready;
    bdsd_pkg::t_col data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bdsd_det_if;
    logic          valid;
    logic          ready;
    bdsd_pkg::t_det data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bdsd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bdsd_pkg::CFG_IDX_W-1:0] index;
    logic [bdsd_pkg::CFG_DAT_W-1:0] value;
    modport source (output valid, output index, output value, input ready);
    modport sink   (input valid, input index, input value, output ready);
endinterface

@@ rtl/bdsd_front.sv @@
// Running argmax over the columns of a frame; queues the winner at frame end if its score is above the threshold.
module bdsd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_thresh,
    bdsd_col_if.sink          i_col,
    input  bdsd_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output bdsd_pkg::t_rec    o_rec
);

    bdsd_pkg::t_rec r_best;
    bdsd_pkg::t_rec n_best;
    bdsd_pkg::t_rec in_rec;
    bdsd_pkg::t_rec merged;
    logic [bdsd_pkg::POINT_FIELDS-1:0][31:0] pts_in;
    logic better;
    logic beat;

    assign i_col.ready = !i_q_stat.full;
    assign beat        = i_col.valid && i_col.ready;

    always_comb begin
        pts_in[0] = i_col.data.point_zero;
        pts_in[1] = i_col.data.point_one;
        pts_in[2] = i_col.data.point_two;
        pts_in[3] = i_col.data.point_three;
        pts_in[4] = i_col.data.point_four;
        in_rec.score      = i_col.data.score;
        in_rec.centre_x   = i_col.data.centre_x;
        in_rec.centre_y   = i_col.data.centre_y;
        in_rec.box_width  = i_col.data.box_width;
        in_rec.box_height = i_col.data.box_height;
        for (int i = 0; i < bdsd_pkg::POINT_FIELDS; i++) begin
            in_rec.points[i] = (i < bdsd_pkg::LIVE_POINTS) ? pts_in[i] : 32'd0;
        end
        // strict compare: first column wins a tie
        better = i_col.data.score > r_best.score;
        merged = better ? in_rec : r_best;
        o_rec  = merged;
        o_push = beat && i_col.data.last_column && (merged.score > i_thresh);
        n_best = r_best;
        if (beat) begin
            n_best = i_col.data.last_column ? '0 : merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
        end else begin
            r_best <= n_best;
        end
    end

endmodule

@@ rtl/bdsd_queue.sv @@
// Short FIFO of winning columns between selector and decoder.
`include "best_detection_select_decode_macros.svh"
module bdsd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bdsd_pkg::t_rec    i_rec,
    input  logic              i_pop,
    output bdsd_pkg::t_rec    o_rec,
    output bdsd_pkg::t_q_stat o_stat
);

    bdsd_pkg::t_rec                 r_slot [bdsd_pkg::QDEPTH];
    logic [bdsd_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [bdsd_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [bdsd_pkg::QCNT_W-1:0]    r_count;
    logic [bdsd_pkg::QPTR_W-1:0]    n_wr_ptr;
    logic [bdsd_pkg::QPTR_W-1:0]    n_rd_ptr;
    logic [bdsd_pkg::QCNT_W-1:0]    n_count;

    localparam logic [bdsd_pkg::QPTR_W-1:0] PTR_LAST = bdsd_pkg::QPTR_W'(bdsd_pkg::QDEPTH - 1);
    localparam logic [bdsd_pkg::QCNT_W-1:0] CNT_FULL = bdsd_pkg::QCNT_W'(bdsd_pkg::QDEPTH);

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign o_rec        = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `BDSD_ASSERT_IMP(a_no_push_full, i_push, !o_stat.full, "push into full queue")
    `BDSD_ASSERT_IMP(a_no_pop_empty, i_pop, !o_stat.empty, "pop from empty queue")
    `BDSD_ASSERT_NXT(a_cnt_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count slip")

endmodule

@@ rtl/bdsd_back.sv @@
// Decoder: scales the queued winner. Stage 1 multiplies, stage 2 rounds
// toward zero and saturates into the output register.
`include "best_detection_select_decode_macros.svh"
module bdsd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_scale,
    input  bdsd_pkg::t_rec    i_rec,
    input  bdsd_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    bdsd_det_if.source        o_det
);

    localparam int PF = bdsd_pkg::POINT_FIELDS;

    function automatic logic signed [15:0] trunc_sat(input logic signed [35:0] p,
                                                     input int unsigned sh);
        logic signed [35:0] bias;
        logic signed [35:0] q;
        bias = p[35] ? $signed(~({36{1'b1}} << sh)) : 36'sd0;
        q = (p + bias) >>> sh;
        if (q > 36'sd32767) begin
            return 16'sh7fff;
        end else if (q < -36'sd32768) begin
            return 16'sh8000;
        end else begin
            return q[15:0];
        end
    endfunction

    // stage 1
    logic                r_s1_vld;
    logic [15:0]         r_s1_score;
    logic signed [34:0]  r_p_left;
    logic signed [34:0]  r_p_top;
    logic [30:0]         r_p_w;
    logic [30:0]         r_p_h;
    logic signed [32:0]  r_px [PF];
    logic signed [32:0]  r_py [PF];
    // output
    logic                r_out_vld;
    bdsd_pkg::t_det      r_out;
    bdsd_pkg::t_det      n_out;
    logic [PF-1:0][31:0] n_pts;

    logic               out_adv;
    logic               s1_adv;
    logic signed [16:0] s17;
    logic signed [17:0] a_left;
    logic signed [17:0] a_top;

    assign out_adv = !r_out_vld || o_det.ready;
    assign s1_adv  = !r_s1_vld || out_adv;
    assign o_pop   = !i_q_stat.empty && s1_adv;

    assign s17    = $signed({1'b0, i_scale});
    assign a_left = $signed({i_rec.centre_x[15], i_rec.centre_x, 1'b0})
                  - $signed({3'b000, i_rec.box_width});
    assign a_top  = $signed({i_rec.centre_y[15], i_rec.centre_y, 1'b0})
                  - $signed({3'b000, i_rec.box_height});

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_score <= i_rec.score;
            r_p_left   <= a_left * s17;
            r_p_top    <= a_top * s17;
            r_p_w      <= i_rec.box_width * i_scale;
            r_p_h      <= i_rec.box_height * i_scale;
            for (int i = 0; i < PF; i++) begin
                r_px[i] <= $signed(i_rec.points[i][31:16]) * s17;
                r_py[i] <= $signed(i_rec.points[i][15:0]) * s17;
            end
        end
    end

    always_comb begin
        n_out.best_score = r_s1_score;
        n_out.left_edge  = trunc_sat({r_p_left[34], r_p_left}, bdsd_pkg::SHIFT_BOX);
        n_out.top_edge   = trunc_sat({r_p_top[34], r_p_top}, bdsd_pkg::SHIFT_BOX);
        // size products are non-negative and stay below 2^15 after the shift
        n_out.out_width  = $signed({1'b0, r_p_w[30:bdsd_pkg::SHIFT_SIZE]});
        n_out.out_height = $signed({1'b0, r_p_h[30:bdsd_pkg::SHIFT_SIZE]});
        for (int i = 0; i < PF; i++) begin
            n_pts[i] = {trunc_sat({{3{r_px[i][32]}}, r_px[i]}, bdsd_pkg::SHIFT_POINT),
                        trunc_sat({{3{r_py[i][32]}}, r_py[i]}, bdsd_pkg::SHIFT_POINT)};
        end
        n_out.image_point_zero  = n_pts[0];
        n_out.image_point_one   = n_pts[1];
        n_out.image_point_two   = n_pts[2];
        n_out.image_point_three = n_pts[3];
        n_out.image_point_four  = n_pts[4];
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_vld <= o_pop;
            end
            if (out_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    assign o_det.valid = r_out_vld;
    assign o_det.data  = r_out;

    `BDSD_ASSERT_NXT(a_s1_hold, r_s1_vld && !s1_adv, r_s1_vld, "stage 1 beat dropped")
    `BDSD_ASSERT_NXT(a_pop_load, o_pop, r_s1_vld, "popped beat not in stage 1")
    `BDSD_ASSERT_IMP(a_size_pos, r_out_vld, !r_out.out_width[15] && !r_out.out_height[15], "negative size")

endmodule

@@ rtl/best_detection_select_decode.sv @@
// Best detection select and decode. Takes one detector output column per
// beat on i_col (score Q0.16, box centre/size and five keypoints in
// Q12.4, last_column flag), keeps the column with the strictly highest
// score of the frame (first one wins a tie, nothing held at score zero),
// and on the last column queues it if its score is strictly above
// score_threshold. The queued winner is scaled by scale_factor (Q4.12):
// box corner and size come out as integer pixels, keypoints stay Q12.4,
// all truncated toward zero and saturated to signed 16 bits. Held state
// is cleared after every last column, whether or not a result is given.
// Rate: one column per clock, sustained; i_col.ready drops only while the
// two-entry winner queue is full, i.e. when results back up on o_det.
// o_det.valid rises once the last column's winner has passed the queue
// write, the multiply stage and the round/saturate stage, each of which
// can be held by back-pressure from o_det.
// Config: i_cfg index 0 = scale_factor, 1 = score_threshold, other
// indexes ignored; always ready. Write only while the block is idle.
module best_detection_select_decode (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdsd_col_if.sink   i_col,
    bdsd_cfg_if.sink   i_cfg,
    bdsd_det_if.source o_det
);

    // config registers
    logic [15:0] r_scale;
    logic [15:0] r_thresh;
    logic        cfg_beat;

    // front -> queue -> back
    logic              q_push;
    logic              q_pop;
    bdsd_pkg::t_rec    q_wr_rec;
    bdsd_pkg::t_rec    q_rd_rec;
    bdsd_pkg::t_q_stat q_stat;

    assign i_cfg.ready = 1'b1;
    assign cfg_beat    = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= bdsd_pkg::SCALE_RESET;
            r_thresh <= bdsd_pkg::THRESHOLD_RESET;
        end else if (cfg_beat) begin
            if (i_cfg.index == bdsd_pkg::CFG_SCALE_FACTOR) begin
                r_scale <= i_cfg.value;
            end
            if (i_cfg.index == bdsd_pkg::CFG_SCORE_THRESHOLD) begin
                r_thresh <= i_cfg.value;
            end
        end
    end

    // running argmax; pushes the frame winner on the last column if it beats the threshold
    bdsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_thresh (r_thresh),
        .i_col    (i_col),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_rec    (q_wr_rec)
    );

    // decouples selection from the decode pipeline and o_det back-pressure
    bdsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_wr_rec),
        .i_pop   (q_pop),
        .o_rec   (q_rd_rec),
        .o_stat  (q_stat)
    );

    // scaling, rounding toward zero, saturation, output register
    bdsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scale  (r_scale),
        .i_rec    (q_rd_rec),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_det    (o_det)
    );

endmodule
